FILE: rtl/core/pfa_pkg.sv
// Shared types and constants for the paged frame allocator.
// Depends on nothing; imported by the top level.
package pfa_pkg;

    // Parameter defaults
    localparam int DEF_NUM_FRAMES = 32;
    localparam int DEF_MAX_PAGES  = 16;
    localparam int DEF_PAGE_BYTES = 1024;

    // Fixed field widths
    localparam int OWNER_W     = 8;
    localparam int MEM_SIZE_W  = 16;
    localparam int OUT_FRAME_W = 5;
    localparam int PAGE_IDX_W  = 4;

    // Pick list: one entry per page an item can return
    localparam int PICK_DEPTH = 16;
    localparam int PICK_AW    = 4;
    localparam int PCNT_W     = 5;   // holds 0..PICK_DEPTH

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_LIMIT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SCAN,
        ST_OUT,
        ST_RESP
    } state_t;

    typedef struct packed {
        status_t                  status;
        logic                     page_valid;
        logic [PAGE_IDX_W-1:0]    page_index;
        logic [OUT_FRAME_W-1:0]   frame_index;
        logic                     last;
    } result_t;

endpackage

FILE: rtl/core/paged_frame_allocator_unit.sv
// Paged frame allocator top level: sequencer, free map, pick list, output register.
// Uses pfa_pkg, pfa_alu and pfa_ram. Reset (rst_n low) marks every frame free.
// Free item: accepted, then ST_RESP loads its result once the output register is free.
// Allocate item: count steps, then a scan over up to NUM_FRAMES frames, then one result
//   per page, all through the one shared add/compare unit.
// Not ready while an item is in work; the output register holds a result meanwhile.
module paged_frame_allocator_unit
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = DEF_NUM_FRAMES,
    parameter int MAX_PAGES  = DEF_MAX_PAGES,
    parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // owner[7:0], mem_size[23:8], frame[28:24], zero pad
    input  logic        s_tuser,   // cmd
    input  logic        s_tlast,   // free_last
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], page_valid[2], page_index[6:3],
                                   // frame_index[11:7], zero pad
    output logic        m_tlast    // last
);

    // Page count is capped by the pick list depth as well as MAX_PAGES.
    localparam int PAGE_LIMIT  = (MAX_PAGES < PICK_DEPTH) ? MAX_PAGES : PICK_DEPTH;
    localparam int LIMIT_BYTES = PAGE_LIMIT * PAGE_BYTES;
    localparam int ACC_W       = $clog2(LIMIT_BYTES + 1);
    localparam int UNIT_W      = (ACC_W > MEM_SIZE_W) ? ACC_W : MEM_SIZE_W;
    localparam int FIDX_W      = $clog2(NUM_FRAMES);
    localparam int FCNT_W      = $clog2(NUM_FRAMES + 1);

    // Unpack the input item
    logic [OWNER_W-1:0]     in_owner;
    logic [MEM_SIZE_W-1:0]  in_size;
    logic [OUT_FRAME_W-1:0] in_frame;

    assign in_owner = s_tdata[7:0];
    assign in_size  = s_tdata[23:8];
    assign in_frame = s_tdata[28:24];

    // Only free versus taken is ever observed, so each frame keeps one busy bit:
    // a frame is busy when a nonzero owner tag was written into it.
    logic [NUM_FRAMES-1:0]  busy_reg, busy_next;

    state_t                 state_reg, state_next;
    logic                   owner_nz_reg, owner_nz_next;
    logic [MEM_SIZE_W-1:0]  size_reg, size_next;
    logic [UNIT_W-1:0]      acc_reg, acc_next;
    logic [PCNT_W-1:0]      pages_reg, pages_next;
    logic [FCNT_W-1:0]      idx_reg, idx_next;
    logic [PCNT_W-1:0]      found_reg, found_next;
    logic [PICK_AW-1:0]     page_reg, page_next;
    result_t                resp_reg, resp_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_data_reg, out_data_next;

    // Shared unit operands
    logic [UNIT_W-1:0]      alu_add_a, alu_add_b, alu_cmp_a, alu_cmp_b, alu_sum;
    logic                   alu_ge;

    // Pick list port
    logic                   ram_wr_en, ram_rd_en;
    logic [PICK_AW-1:0]     ram_wr_addr, ram_rd_addr;
    logic [FIDX_W-1:0]      ram_wr_data, ram_rd_data;

    // Frame number width conversions
    logic [FIDX_W+OUT_FRAME_W-1:0] free_wide;
    logic [FIDX_W-1:0]             free_idx;
    logic [FIDX_W+OUT_FRAME_W-1:0] pick_wide;
    logic [OUT_FRAME_W-1:0]        pick_frame;
    logic                          free_in_range;
    logic                          slot_free;

    assign free_wide     = {{FIDX_W{1'b0}}, in_frame};
    assign free_idx      = free_wide[FIDX_W-1:0];
    assign pick_wide     = {{OUT_FRAME_W{1'b0}}, ram_rd_data};
    assign pick_frame    = pick_wide[OUT_FRAME_W-1:0];
    assign free_in_range = (32'(in_frame) < NUM_FRAMES);

    // Output register takes a new result when empty or being drained.
    assign slot_free = !out_valid_reg || m_tready;

    pfa_alu #(
        .WIDTH (UNIT_W)
    ) u_alu (
        .add_a (alu_add_a),
        .add_b (alu_add_b),
        .cmp_a (alu_cmp_a),
        .cmp_b (alu_cmp_b),
        .sum   (alu_sum),
        .ge    (alu_ge)
    );

    pfa_ram #(
        .WIDTH (FIDX_W),
        .DEPTH (PICK_DEPTH)
    ) u_pick_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Operand selection for the shared unit, per phase:
    //   count: step the byte total by one page, test it against the size
    //   scan:  advance the frame index, test found pages against the count
    //   out:   advance the page number, test for the final page
    always_comb
    begin
        alu_add_a = acc_reg;
        alu_add_b = UNIT_W'(PAGE_BYTES);
        alu_cmp_a = acc_reg;
        alu_cmp_b = UNIT_W'(size_reg);
        case (state_reg)
            ST_SCAN:
            begin
                alu_add_a = UNIT_W'(idx_reg);
                alu_add_b = UNIT_W'(1);
                alu_cmp_a = UNIT_W'(found_reg);
                alu_cmp_b = UNIT_W'(pages_reg);
            end
            ST_OUT:
            begin
                alu_add_a = UNIT_W'(page_reg);
                alu_add_b = UNIT_W'(1);
                alu_cmp_a = UNIT_W'(page_reg);
                alu_cmp_b = UNIT_W'(pages_reg - PCNT_W'(1));
            end
            default:
            begin
                alu_add_a = acc_reg;
                alu_add_b = UNIT_W'(PAGE_BYTES);
                alu_cmp_a = acc_reg;
                alu_cmp_b = UNIT_W'(size_reg);
            end
        endcase
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        owner_nz_next  = owner_nz_reg;
        size_next      = size_reg;
        acc_next       = acc_reg;
        pages_next     = pages_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        page_next      = page_reg;
        resp_next      = resp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        s_tready       = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = found_reg[PICK_AW-1:0];
        ram_wr_data    = idx_reg[FIDX_W-1:0];
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_FREE)
                    begin
                        // Release one frame; out-of-range frames are left alone
                        if (free_in_range)
                        begin
                            busy_next[free_idx] = 1'b0;
                        end
                        resp_next  = '{STAT_OK, 1'b0, '0, in_frame, s_tlast};
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        owner_nz_next = |in_owner;
                        size_next     = in_size;
                        acc_next      = '0;
                        pages_next    = '0;
                        state_next    = ST_COUNT;
                    end
                end
            end

            ST_COUNT:
            begin
                // Round the size up to pages one page at a time
                if (alu_ge)
                begin
                    if (pages_reg == '0)
                    begin
                        resp_next  = '{STAT_OK, 1'b0, '0, '0, 1'b1};
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        idx_next   = '0;
                        found_next = '0;
                        state_next = ST_SCAN;
                    end
                end
                else if (pages_reg == PCNT_W'(PAGE_LIMIT))
                begin
                    resp_next  = '{STAT_LIMIT, 1'b0, '0, '0, 1'b1};
                    state_next = ST_RESP;
                end
                else
                begin
                    acc_next   = alu_sum;
                    pages_next = pages_reg + PCNT_W'(1);
                end
            end

            ST_SCAN:
            begin
                // First fit: one frame a cycle in index order
                if (alu_ge)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = '0;
                    page_next   = '0;
                    state_next  = ST_OUT;
                end
                else if (idx_reg == FCNT_W'(NUM_FRAMES))
                begin
                    resp_next  = '{STAT_NOFIT, 1'b0, '0, '0, 1'b1};
                    state_next = ST_RESP;
                end
                else
                begin
                    if (!busy_reg[idx_reg[FIDX_W-1:0]])
                    begin
                        ram_wr_en  = 1'b1;
                        found_next = found_reg + PCNT_W'(1);
                    end
                    idx_next = alu_sum[FCNT_W-1:0];
                end
            end

            ST_OUT:
            begin
                // Emit one entry per page and claim its frame if the owner tag is nonzero; prefetch the next pick
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{STAT_OK, 1'b1, page_reg, pick_frame, alu_ge};
                    if (owner_nz_reg)
                    begin
                        busy_next[ram_rd_data] = 1'b1;
                    end
                    if (alu_ge)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = alu_sum[PICK_AW-1:0];
                        page_next   = alu_sum[PICK_AW-1:0];
                    end
                end
            end

            ST_RESP:
            begin
                // Single result of a free, an empty request or a refusal
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = resp_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        owner_nz_reg <= owner_nz_next;
        size_reg     <= size_next;
        acc_reg      <= acc_next;
        pages_reg    <= pages_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        page_reg     <= page_next;
        resp_reg     <= resp_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg.frame_index, out_data_reg.page_index,
                       out_data_reg.page_valid, out_data_reg.status};
    assign m_tlast  = out_data_reg.last;

`ifndef SYNTH
    // The scan never records more frames than the request needs.
    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (found_reg <= pages_reg))
        else $error("pick count ran past the page count");

    // Scanning only reads the free map.
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> $stable(busy_reg))
        else $error("free map changed during scan");

    // Every frame handed out was free when picked.
    a_pick_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && slot_free) |-> !busy_reg[ram_rd_data])
        else $error("allocated a frame that is already taken");

    // Page numbers stay below the page count while emitting.
    a_page_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (PCNT_W'(page_reg) < pages_reg))
        else $error("page number past the page count");
`endif

endmodule

FILE: rtl/core/pfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the list of picked frames.
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/pfa_alu.sv
// Shared add-and-compare unit used by the count, scan and out phases of the sequencer.
// Depends on nothing; operands are picked by the top-level sequencer.
module pfa_alu #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0] add_a,
    input  logic [WIDTH-1:0] add_b,
    input  logic [WIDTH-1:0] cmp_a,
    input  logic [WIDTH-1:0] cmp_b,
    output logic [WIDTH-1:0] sum,
    output logic             ge
);

    assign sum = add_a + add_b;
    assign ge  = (cmp_a >= cmp_b);

endmodule
